>>> hdl/bblru_pkg.sv
package bblru_pkg;

   localparam int DEF_ENTRIES = 32;
   localparam logic [31:0] RESET_LIMIT = 32'd805306368; // 768 MiB

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT_CHK,
      ST_EVICT,
      ST_SHIFT_DN,
      ST_FRONT,
      ST_SHIFT_UP,
      ST_STATUS
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] entry_key;
      logic [24:0] entry_bytes;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        hit;
      logic [15:0] evicted_key;
      logic        over_budget;
      logic [31:0] used_bytes;
      logic        last;
   } rsp_type;

   // one cache line as stored, indexed by recency position
   typedef struct packed {
      logic [15:0] key;
      logic [24:0] bytes;
   } entry_type;

endpackage

>>> hdl/bblru_mem.sv
module bblru_mem
   import bblru_pkg::*;
#(
   parameter int DEPTH = DEF_ENTRIES,
   parameter int AW    = $clog2(DEF_ENTRIES)
) (
   input  logic      clock,
   input  logic      wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bblru_ctrl.sv
module bblru_ctrl
   import bblru_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int AW      = $clog2(DEF_ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output entry_type     mem_wr_data,
   output logic [AW-1:0] mem_rd_addr,
   input  entry_type     mem_rd_data
);

   localparam int CW = $clog2(ENTRIES + 1);

   state_type     state_ff, state_in;
   cmd_type       cmd_ff;
   logic [15:0]   key_ff;
   logic [24:0]   bytes_ff;
   entry_type     ent_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] dst_ff;
   logic [CW-1:0] count_ff;
   logic [31:0]   used_ff;
   logic [31:0]   limit_ff;
   logic          hit_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          accept;
   logic [AW-1:0] count_m1;
   logic          key_match;
   logic          at_tail;
   logic [32:0]   sum_wide;
   logic [31:0]   used_add;
   logic [31:0]   used_sub;
   logic          need_evict;
   logic          up_done;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign count_m1  = AW'(count_ff - CW'(1));
   assign key_match = (mem_rd_data.key == key_ff);
   assign at_tail   = (pos_ff == count_m1);
   assign sum_wide  = {1'b0, used_ff} + 33'(bytes_ff);
   assign used_add  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
   assign used_sub  = (used_ff >= 32'(mem_rd_data.bytes)) ?
                      used_ff - 32'(mem_rd_data.bytes) : 32'd0;
   assign need_evict = (count_ff != '0) &&
                       ((count_ff >= CW'(ENTRIES)) || (sum_wide > {1'b0, limit_ff}));
   // count already decremented on the hit
   assign up_done   = ((CW'(dst_ff) + CW'(1)) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_CLEAR) begin
                  state_in = ST_STATUS;
               end else if (count_ff == '0) begin
                  state_in = (req_data.cmd == CMD_FILL) ? ST_EVICT_CHK : ST_STATUS;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               if (cmd_ff == CMD_REMOVE) begin
                  state_in = at_tail ? ST_STATUS : ST_SHIFT_UP;
               end else begin
                  state_in = (pos_ff == '0) ? ST_STATUS : ST_SHIFT_DN;
               end
            end else if (at_tail) begin
               state_in = (cmd_ff == CMD_FILL) ? ST_EVICT_CHK : ST_STATUS;
            end
         end
         ST_EVICT_CHK: begin
            if (need_evict) begin
               state_in = ST_EVICT;
            end else begin
               state_in = (count_ff == '0) ? ST_FRONT : ST_SHIFT_DN;
            end
         end
         ST_EVICT:    state_in = ST_EVICT_CHK;
         ST_SHIFT_DN: state_in = (dst_ff == AW'(1)) ? ST_FRONT : ST_SHIFT_DN;
         ST_FRONT:    state_in = ST_STATUS;
         ST_SHIFT_UP: state_in = up_done ? ST_STATUS : ST_SHIFT_UP;
         ST_STATUS:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = dst_ff;
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         ST_IDLE: mem_rd_addr = '0;
         ST_SCAN: begin
            if (key_match) begin
               mem_rd_addr = (cmd_ff == CMD_REMOVE) ? AW'(pos_ff + AW'(1))
                                                    : AW'(pos_ff - AW'(1));
            end else begin
               mem_rd_addr = AW'(pos_ff + AW'(1));
            end
         end
         ST_EVICT_CHK: mem_rd_addr = count_m1;
         ST_EVICT:     mem_rd_addr = '0;
         ST_SHIFT_DN: begin
            mem_wr_en   = 1'b1;
            mem_rd_addr = AW'(dst_ff - AW'(2));
         end
         ST_FRONT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = ent_ff;
         end
         ST_SHIFT_UP: begin
            mem_wr_en   = 1'b1;
            mem_rd_addr = AW'(dst_ff + AW'(2));
         end
         ST_STATUS: mem_rd_addr = '0;
         default:   mem_rd_addr = '0;
      endcase
   end

   // result item of this cycle
   always_comb begin
      rsp_in = '0;
      if (state_ff == ST_EVICT) begin
         rsp_in.evicted_key = mem_rd_data.key;
         rsp_in.used_bytes  = used_sub;
      end else begin
         rsp_in.result_kind = 1'b1;
         rsp_in.hit         = hit_ff;
         rsp_in.over_budget = (used_ff > limit_ff);
         rsp_in.used_bytes  = used_ff;
         rsp_in.last        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         limit_ff     <= RESET_LIMIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_EVICT) || (state_ff == ST_STATUS);
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_data.cmd == CMD_CLEAR) begin
                  count_ff <= '0;
                  used_ff  <= '0;
               end
            end
            ST_SCAN: begin
               if (key_match && cmd_ff == CMD_REMOVE) begin
                  count_ff <= CW'(count_ff - CW'(1));
                  used_ff  <= used_sub;
               end
            end
            ST_EVICT_CHK: begin
               if (!need_evict) begin
                  count_ff <= CW'(count_ff + CW'(1));
                  used_ff  <= used_add;
               end
            end
            ST_EVICT: begin
               count_ff <= CW'(count_ff - CW'(1));
               used_ff  <= used_sub;
            end
            default: ;
         endcase
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff   <= req_data.cmd;
            key_ff   <= req_data.entry_key;
            bytes_ff <= req_data.entry_bytes;
            hit_ff   <= 1'b0;
            pos_ff   <= '0;
         end
         ST_SCAN: begin
            if (key_match) begin
               hit_ff <= 1'b1;
               ent_ff <= mem_rd_data;
               dst_ff <= pos_ff;
            end else begin
               pos_ff <= AW'(pos_ff + AW'(1));
            end
         end
         ST_EVICT_CHK: begin
            ent_ff <= '{key: key_ff, bytes: bytes_ff};
            dst_ff <= AW'(count_ff);
         end
         ST_SHIFT_DN: dst_ff <= AW'(dst_ff - AW'(1));
         ST_SHIFT_UP: dst_ff <= AW'(dst_ff + AW'(1));
         default: ;
      endcase

      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/byte_budget_lru_cache_core.sv
// channel   | ports                      | handshake
// ----------+----------------------------+----------------------------------
// request   | req_data, start, busy      | taken when start && !busy
// result    | rsp_data, rsp_valid        | one-cycle strobe, no back-pressure
// register  | csr_wr_en, csr_wr_data     | byte_limit written on csr_wr_en
//
// An item keeps busy high while it is worked on: a key search one slot per cycle,
// then the EVICT_CHK and EVICT states for each eviction and one write per slot moved
// when the recency list is shifted, all through the single read / single write entry memory.
// busy falls in the cycle in which the final status item is strobed.
// Reset empties the table and loads the 768 MiB limit; no clearing pass.
// Results cannot be stalled; each is on rsp_data for exactly one cycle.
module byte_budget_lru_cache_core
   import bblru_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int AW = $clog2(ENTRIES);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;

   bblru_ctrl #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bblru_mem #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.result_kind)
      else $error("last item is not a status item");

   a_evict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_kind |-> !rsp_data.hit && !rsp_data.over_budget)
      else $error("eviction item carries status flags");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("block not idle with final item");

endmodule
